// File: design/wts_pkg.sv
// ----------------------------------------------------------------------------
// wts_pkg
// Shared constants, codes and controller/datapath handshake types for the
// window temperature statistics block.
// ----------------------------------------------------------------------------
package wts_pkg;

  localparam int RING_DEPTH = 64;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int VAL_W      = 16;
  localparam int LEN_W      = 10;
  localparam int OUT_W      = 20;
  localparam int UNIT_W     = 2;
  localparam int ENTRY_W    = VAL_W + 1;
  localparam int SUM_W      = VAL_W + CNT_W;
  localparam int DCNT_W     = $clog2(SUM_W + 1);
  localparam int CMP_W      = (LEN_W > CNT_W) ? LEN_W : CNT_W;

  // Fahrenheit scaling: |v * 9| fits MAG9_W bits, and the quotient by five
  // comes from a reciprocal multiply that is exact over that range.
  localparam int MAG9_W       = 19;
  localparam int RECIP5_SHIFT = 21;
  localparam int RECIP5_MULT  = 419431;
  localparam int Q5_W         = 17;
  localparam int PROD_W       = 2 * MAG9_W;

  localparam int F_OFFSET = 8192;
  localparam int K_OFFSET = 69926;

  localparam logic [UNIT_W-1:0] UNIT_CELSIUS    = 2'd0;
  localparam logic [UNIT_W-1:0] UNIT_FAHRENHEIT = 2'd1;
  localparam logic [UNIT_W-1:0] UNIT_KELVIN     = 2'd2;

  localparam logic ACT_STORE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [1:0] SEL_MEAN = 2'd0;
  localparam logic [1:0] SEL_MIN  = 2'd1;
  localparam logic [1:0] SEL_MAX  = 2'd2;

  typedef struct packed {
    logic store;
    logic query;
    logic walk;
    logic div_init;
    logic div_step;
    logic conv_a;
    logic conv_b;
    logic conv_c;
    logic load_out;
  } wts_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic div_last;
    logic conv_last;
    logic out_free;
  } wts_status_t;

endpackage

// File: design/wts_ctrl.sv
// ----------------------------------------------------------------------------
// wts_ctrl
// Sequencer for the statistics block: accepts items, walks the ring, runs the
// divider and the unit converter, and hands the result to the output stage.
// ----------------------------------------------------------------------------
module wts_ctrl import wts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        action,
  input  wts_status_t status,
  output logic        in_stall,
  output wts_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_DIVI  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_CONVA = 3'd4;
  localparam logic [2:0] S_CONVB = 3'd5;
  localparam logic [2:0] S_CONVC = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (action == ACT_QUERY) begin
            cmd.query  = 1'b1;
            state_next = S_WALK;
          end else begin
            cmd.store = 1'b1;
          end
        end
      end
      S_WALK: begin
        // The last read lands and is accumulated in the cycle that sees
        // the walk finished, so the divider can load right after.
        cmd.walk = 1'b1;
        if (status.walk_done) begin
          state_next = S_DIVI;
        end
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_CONVA;
        end
      end
      S_CONVA: begin
        cmd.conv_a = 1'b1;
        state_next = S_CONVB;
      end
      S_CONVB: begin
        cmd.conv_b = 1'b1;
        state_next = S_CONVC;
      end
      S_CONVC: begin
        cmd.conv_c = 1'b1;
        state_next = status.conv_last ? S_OUT : S_CONVA;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: design/wts_dp.sv
// ----------------------------------------------------------------------------
// wts_dp
// Datapath: sample ring memory, window walk with sum/min/max accumulation,
// bit-serial divider for the mean, unit converter and output register.
// ----------------------------------------------------------------------------
module wts_dp import wts_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  wts_cmd_t                cmd,
  output wts_status_t             status,
  input  logic                    cfg_valid,
  input  logic [UNIT_W-1:0]       cfg_data,
  input  logic signed [VAL_W-1:0] sample_value,
  input  logic                    sample_valid,
  input  logic [LEN_W-1:0]        window_length,
  input  logic                    out_stall,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] mean_value,
  output logic signed [OUT_W-1:0] min_value,
  output logic signed [OUT_W-1:0] max_value,
  output logic                    any_valid
);

  logic [ENTRY_W-1:0] mem [RING_DEPTH];
  logic [ENTRY_W-1:0] rd_data;

  logic [UNIT_W-1:0] unit_sel;
  logic [PTR_W-1:0]  wp;
  logic [CNT_W-1:0]  held;
  logic [PTR_W-1:0]  ptr;
  logic [PTR_W-1:0]  ptr_prev;
  logic [PTR_W-1:0]  wp_inc;
  logic [CNT_W-1:0]  remaining;
  logic              rd_pend;
  logic              issue;

  logic signed [SUM_W-1:0] sum;
  logic [CNT_W-1:0]        count;
  logic signed [VAL_W-1:0] mn;
  logic signed [VAL_W-1:0] mx;
  logic signed [VAL_W-1:0] rd_val;

  logic [SUM_W-1:0]  sum_mag;
  logic              sum_neg;
  logic [SUM_W-1:0]  div_quo;
  logic [CNT_W:0]    div_rem;
  logic [CNT_W:0]    div_shift;
  logic              div_ge;
  logic [DCNT_W-1:0] div_cnt;

  logic [1:0]              conv_idx;
  logic signed [VAL_W-1:0] mean16;
  logic signed [VAL_W-1:0] sel_val;
  logic signed [OUT_W-1:0] x9;
  logic signed [VAL_W-1:0] cur_val;
  logic                    neg9;
  logic [MAG9_W-1:0]       mag9;
  logic [PROD_W-1:0]       prod;
  logic [Q5_W-1:0]         q5;
  logic [OUT_W-1:0]        q5_signed;
  logic signed [OUT_W-1:0] conv_val;
  logic signed [OUT_W-1:0] res_mean;
  logic signed [OUT_W-1:0] res_min;
  logic signed [OUT_W-1:0] res_max;

  assign ptr_prev = (ptr == '0) ? PTR_W'(RING_DEPTH - 1) : ptr - 1'b1;
  assign wp_inc   = (wp == PTR_W'(RING_DEPTH - 1)) ? '0 : wp + 1'b1;
  assign issue    = cmd.walk && (remaining != '0);
  assign rd_val   = rd_data[VAL_W-1:0];

  assign sum_mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

  assign div_shift = {div_rem[CNT_W-1:0], div_quo[SUM_W-1]};
  assign div_ge    = (div_shift >= {1'b0, count});

  assign mean16 = sum_neg ? -signed'(div_quo[VAL_W-1:0]) : signed'(div_quo[VAL_W-1:0]);

  always_comb begin
    case (conv_idx)
      SEL_MEAN: sel_val = mean16;
      SEL_MIN:  sel_val = mn;
      default:  sel_val = mx;
    endcase
  end

  assign x9   = (OUT_W'(sel_val) <<< 3) + OUT_W'(sel_val);
  assign prod = PROD_W'(mag9) * PROD_W'(RECIP5_MULT);

  assign q5_signed = neg9 ? -OUT_W'(q5) : OUT_W'(q5);

  always_comb begin
    case (unit_sel)
      UNIT_FAHRENHEIT: conv_val = signed'(q5_signed + OUT_W'(F_OFFSET));
      UNIT_KELVIN:     conv_val = OUT_W'(cur_val) + OUT_W'(K_OFFSET);
      default:         conv_val = OUT_W'(cur_val);
    endcase
  end

  assign status.walk_done = (remaining == '0);
  assign status.div_last  = (div_cnt == DCNT_W'(1));
  assign status.conv_last = (conv_idx == SEL_MAX);
  assign status.out_free  = !out_valid || !out_stall;

  // Ring memory with a registered read port.
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[wp] <= {sample_valid, sample_value};
    end
    if (issue) begin
      rd_data <= mem[ptr_prev];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_sel  <= UNIT_CELSIUS;
      wp        <= '0;
      held      <= '0;
      remaining <= '0;
      rd_pend   <= 1'b0;
      div_cnt   <= '0;
      conv_idx  <= SEL_MEAN;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unit_sel <= cfg_data;
      end
      if (cmd.store) begin
        wp <= wp_inc;
        if (held != CNT_W'(RING_DEPTH)) begin
          held <= held + 1'b1;
        end
      end
      if (cmd.query) begin
        remaining <= (CMP_W'(window_length) > CMP_W'(held)) ? held : CNT_W'(window_length);
        conv_idx  <= SEL_MEAN;
      end else if (issue) begin
        remaining <= remaining - 1'b1;
      end
      rd_pend <= issue;
      if (cmd.div_init) begin
        div_cnt <= DCNT_W'(SUM_W);
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt - 1'b1;
      end
      if (cmd.conv_c) begin
        conv_idx <= conv_idx + 1'b1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Walk, accumulate, divide and convert.
  always_ff @(posedge clk) begin
    if (cmd.query) begin
      ptr   <= wp;
      sum   <= '0;
      count <= '0;
      mn    <= '0;
      mx    <= '0;
    end else begin
      if (issue) begin
        ptr <= ptr_prev;
      end
      if (rd_pend && rd_data[VAL_W]) begin
        sum   <= sum + SUM_W'(rd_val);
        count <= count + 1'b1;
        if (count == '0 || rd_val < mn) begin
          mn <= rd_val;
        end
        if (count == '0 || rd_val > mx) begin
          mx <= rd_val;
        end
      end
    end

    if (cmd.div_init) begin
      sum_neg <= sum[SUM_W-1];
      div_quo <= sum_mag;
      div_rem <= '0;
    end else if (cmd.div_step) begin
      div_rem <= div_ge ? div_shift - {1'b0, count} : div_shift;
      div_quo <= {div_quo[SUM_W-2:0], div_ge};
    end

    if (cmd.conv_a) begin
      cur_val <= sel_val;
      neg9    <= sel_val[VAL_W-1];
      mag9    <= x9[OUT_W-1] ? MAG9_W'(-x9) : MAG9_W'(x9);
    end
    if (cmd.conv_b) begin
      q5 <= prod[RECIP5_SHIFT +: Q5_W];
    end
    if (cmd.conv_c) begin
      case (conv_idx)
        SEL_MEAN: res_mean <= conv_val;
        SEL_MIN:  res_min  <= conv_val;
        default:  res_max  <= conv_val;
      endcase
    end

    if (cmd.load_out) begin
      if (count == '0) begin
        mean_value <= '0;
        min_value  <= '0;
        max_value  <= '0;
        any_valid  <= 1'b0;
      end else begin
        mean_value <= res_mean;
        min_value  <= res_min;
        max_value  <= res_max;
        any_valid  <= 1'b1;
      end
    end
  end

endmodule

// File: design/window_temperature_statistics.sv
// ----------------------------------------------------------------------------
// window_temperature_statistics
// Ring of recent Q8.8 Celsius samples with windowed mean, minimum and maximum,
// reported in Celsius, Fahrenheit or Kelvin.
// ----------------------------------------------------------------------------
// A store transfer leaves the block idle, so it is ready for the next item in
// the following cycle. A query transfer holds the input while the ring memory,
// which has one read port, delivers one sample per cycle for each of the L
// samples in the window (L is the window length after clamping to the samples
// held); the mean then comes from a divider that makes one quotient bit per
// cycle, the unit conversion handles the three values one after another, each
// in steps A, B and C, and a final step loads the output register. A result
// waiting on the output does not block store transfers; a following query
// waits only at its final step until the output register is free.
module window_temperature_statistics import wts_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    action,
  input  logic signed [VAL_W-1:0] sample_value,
  input  logic                    sample_valid,
  input  logic [LEN_W-1:0]        window_length,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] mean_value,
  output logic signed [OUT_W-1:0] min_value,
  output logic signed [OUT_W-1:0] max_value,
  output logic                    any_valid,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [UNIT_W-1:0]       cfg_data
);

  wts_cmd_t    cmd;
  wts_status_t status;
  logic        cfg_write;

  // The unit register can take a write in any cycle.
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  wts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  wts_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .cfg_valid     (cfg_write),
    .cfg_data      (cfg_data),
    .sample_value  (sample_value),
    .sample_valid  (sample_valid),
    .window_length (window_length),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .mean_value    (mean_value),
    .min_value     (min_value),
    .max_value     (max_value),
    .any_valid     (any_valid)
  );

endmodule
